// ===== design/psfrl_pkg.sv =====
// Package of the per-source flood rate limiter.
// Holds codes, constants, register reset values and the structs shared by the top, front and back modules.
// No dependencies.
package psfrl_pkg;

  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] GAME_PORT_LOW  = 16'd25565;
  localparam logic [15:0] GAME_PORT_HIGH = 16'd25600;
  localparam logic [15:0] SSH_PORT       = 16'd22;
  localparam logic [15:0] DNS_PORT       = 16'd53;

  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;
  localparam int          HASH_BITS = 24;

  localparam logic [31:0] RST_SYN_WINDOW = 32'd1000000000;
  localparam logic [15:0] RST_SYN_LIMIT  = 16'd100;
  localparam logic [31:0] RST_UDP_WINDOW = 32'd1000000000;
  localparam logic [15:0] RST_UDP_LIMIT  = 16'd200;
  localparam logic [15:0] RST_DNS_LIMIT  = 16'd50;
  localparam logic [31:0] RST_HS_WINDOW  = 32'd200000000;
  localparam logic [15:0] RST_HS_LIMIT   = 16'd5;

  typedef enum logic [2:0] {
    CFG_SYN_WINDOW = 3'd0,
    CFG_SYN_LIMIT  = 3'd1,
    CFG_UDP_WINDOW = 3'd2,
    CFG_UDP_LIMIT  = 3'd3,
    CFG_DNS_LIMIT  = 3'd4,
    CFG_HS_WINDOW  = 3'd5,
    CFG_HS_LIMIT   = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RSN_NONE = 3'd0,
    RSN_SYN  = 3'd1,
    RSN_HS   = 3'd2,
    RSN_UDP  = 3'd3,
    RSN_SSH  = 3'd4
  } reason_t;

  typedef struct packed {
    logic [31:0] syn_window;
    logic [15:0] syn_limit;
    logic [31:0] udp_window;
    logic [15:0] udp_limit;
    logic [15:0] dns_limit;
    logic [31:0] hs_window;
    logic [15:0] hs_limit;
  } cfg_t;

  typedef struct packed {
    logic        ok;
    logic        syn_op;
    logic        hs_op;
    logic        ssh_op;
    logic        udp_op;
    logic        dns;
    logic [31:0] src;
    logic [15:0] dport;
    logic [63:0] now;
  } cls_t;

  typedef struct packed {
    logic        drop;
    reason_t     reason;
    logic [31:0] banned_addr;
    logic        rep_valid;
    logic [15:0] rep_port;
  } res_t;

endpackage

// ===== design/per_source_flood_rate_limiter_top.sv =====
// Top level of the per-source flood rate limiter: configuration registers, front, queues, back.
// Depends on psfrl_pkg, psfrl_front, psfrl_fifo, psfrl_back.
//
//   channel   handshake         payload
//   in_       in_push/in_full   header summary fields and time_ns
//   out_      out_pop/out_empty drop, ban_reason, banned_addr, port reports
//   cfg_      cfg_we            cfg_addr, cfg_wdata (32 bits)
//
// An item passes the hashing pipeline registers c0_r, c1_r and c2_r, then the table update.
// The back part takes no new item until the last is through: a table read, then a write.
// After reset the tag tables are cleared, one slot per cycle over the larger table
// depth (4096 by default); in_full stays high until this is done.
module per_source_flood_rate_limiter_top #(
  parameter int RATE_TABLE_DEPTH = 4096,
  parameter int BAN_TABLE_DEPTH  = 4096,
  parameter int COUNT_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_frame_ok,
  input  logic        in_transport_ok,
  input  logic [31:0] in_source_addr,
  input  logic [7:0]  in_ip_protocol,
  input  logic        in_flag_syn,
  input  logic        in_flag_ack,
  input  logic        in_flag_psh,
  input  logic [15:0] in_dest_port,
  input  logic [15:0] in_payload_length,
  input  logic [7:0]  in_payload_first,
  input  logic [7:0]  in_payload_second,
  input  logic [63:0] in_time_ns,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_drop,
  output logic [2:0]  out_ban_reason,
  output logic [31:0] out_banned_addr,
  output logic        out_port_report_valid,
  output logic [15:0] out_port_report
);

  localparam int SB = $clog2(BAN_TABLE_DEPTH);
  localparam int SR = $clog2(RATE_TABLE_DEPTH);
  localparam int QW = $bits(psfrl_pkg::cls_t) + SB + SR;
  localparam int RW = $bits(psfrl_pkg::res_t);

  psfrl_pkg::cfg_t cfg_r;
  psfrl_pkg::cls_t f_cls, b_cls;
  psfrl_pkg::res_t b_res, o_res;
  logic [SB-1:0]   f_bslot, b_bslot;
  logic [SR-1:0]   f_rslot, b_rslot;
  logic [QW-1:0]   q_rd;
  logic [RW-1:0]   o_rd;
  logic            busy, q_push, q_full, q_empty, q_pop, o_push, o_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.syn_window <= psfrl_pkg::RST_SYN_WINDOW;
      cfg_r.syn_limit  <= psfrl_pkg::RST_SYN_LIMIT;
      cfg_r.udp_window <= psfrl_pkg::RST_UDP_WINDOW;
      cfg_r.udp_limit  <= psfrl_pkg::RST_UDP_LIMIT;
      cfg_r.dns_limit  <= psfrl_pkg::RST_DNS_LIMIT;
      cfg_r.hs_window  <= psfrl_pkg::RST_HS_WINDOW;
      cfg_r.hs_limit   <= psfrl_pkg::RST_HS_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        psfrl_pkg::CFG_SYN_WINDOW: cfg_r.syn_window <= cfg_wdata;
        psfrl_pkg::CFG_SYN_LIMIT:  cfg_r.syn_limit  <= cfg_wdata[15:0];
        psfrl_pkg::CFG_UDP_WINDOW: cfg_r.udp_window <= cfg_wdata;
        psfrl_pkg::CFG_UDP_LIMIT:  cfg_r.udp_limit  <= cfg_wdata[15:0];
        psfrl_pkg::CFG_DNS_LIMIT:  cfg_r.dns_limit  <= cfg_wdata[15:0];
        psfrl_pkg::CFG_HS_WINDOW:  cfg_r.hs_window  <= cfg_wdata;
        psfrl_pkg::CFG_HS_LIMIT:   cfg_r.hs_limit   <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  psfrl_front #(.BAN_DEPTH(BAN_TABLE_DEPTH), .RATE_DEPTH(RATE_TABLE_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .busy(busy), .in_push(in_push), .in_full(in_full),
    .frame_ok(in_frame_ok), .transport_ok(in_transport_ok), .source_addr(in_source_addr),
    .ip_protocol(in_ip_protocol), .flag_syn(in_flag_syn), .flag_ack(in_flag_ack),
    .flag_psh(in_flag_psh), .dest_port(in_dest_port), .payload_length(in_payload_length),
    .payload_first(in_payload_first), .payload_second(in_payload_second),
    .time_ns(in_time_ns), .q_full(q_full), .q_push(q_push), .q_cls(f_cls),
    .q_ban_slot(f_bslot), .q_rate_slot(f_rslot));

  psfrl_fifo #(.WIDTH(QW), .DEPTH(2)) u_mid_q (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata({f_cls, f_bslot, f_rslot}),
    .pop(q_pop), .rdata(q_rd), .empty(q_empty), .full(q_full));

  assign {b_cls, b_bslot, b_rslot} = q_rd;

  psfrl_back #(
    .BAN_DEPTH(BAN_TABLE_DEPTH), .RATE_DEPTH(RATE_TABLE_DEPTH), .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .busy(busy), .q_empty(q_empty), .q_cls(b_cls),
    .q_ban_slot(b_bslot), .q_rate_slot(b_rslot), .q_pop(q_pop), .o_full(o_full),
    .o_push(o_push), .o_res(b_res));

  psfrl_fifo #(.WIDTH(RW), .DEPTH(2)) u_out_q (
    .clk(clk), .rst_n(rst_n), .push(o_push), .wdata(b_res), .pop(out_pop),
    .rdata(o_rd), .empty(out_empty), .full(o_full));

  assign o_res                 = o_rd;
  assign out_drop              = o_res.drop;
  assign out_ban_reason        = o_res.reason;
  assign out_banned_addr       = o_res.banned_addr;
  assign out_port_report_valid = o_res.rep_valid;
  assign out_port_report       = o_res.rep_port;

endmodule

// ===== design/psfrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psfrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/psfrl_fifo.sv =====
// Small register FIFO used between front and back and in front of the result port.
// No dependencies.
module psfrl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW + 1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== design/psfrl_front.sv =====
// Front part: accepts header summaries, classifies them and hashes the source to table slots.
// Depends on psfrl_pkg.
module psfrl_front #(
  parameter int BAN_DEPTH  = 4096,
  parameter int RATE_DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          busy,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          frame_ok,
  input  logic                          transport_ok,
  input  logic [31:0]                   source_addr,
  input  logic [7:0]                    ip_protocol,
  input  logic                          flag_syn,
  input  logic                          flag_ack,
  input  logic                          flag_psh,
  input  logic [15:0]                   dest_port,
  input  logic [15:0]                   payload_length,
  input  logic [7:0]                    payload_first,
  input  logic [7:0]                    payload_second,
  input  logic [63:0]                   time_ns,
  input  logic                          q_full,
  output logic                          q_push,
  output psfrl_pkg::cls_t               q_cls,
  output logic [$clog2(BAN_DEPTH)-1:0]  q_ban_slot,
  output logic [$clog2(RATE_DEPTH)-1:0] q_rate_slot
);

  localparam int HB = psfrl_pkg::HASH_BITS;
  localparam int SB = $clog2(BAN_DEPTH);
  localparam int SR = $clog2(RATE_DEPTH);
  localparam logic [63:0] MB = ((64'd1 << (HB + SB)) + 64'(BAN_DEPTH) - 64'd1) / 64'(BAN_DEPTH);
  localparam logic [63:0] MR = ((64'd1 << (HB + SR)) + 64'(RATE_DEPTH) - 64'd1) /
                               64'(RATE_DEPTH);
  localparam logic [HB-1:0] DB = HB'(BAN_DEPTH);
  localparam logic [HB-1:0] DR = HB'(RATE_DEPTH);

  psfrl_pkg::cls_t cls_in, c0_r, c1_r, c2_r;
  logic            v0_r, v1_r, v2_r;
  logic            adv, acc, tcp, udp, psh_pay, game;
  logic [31:0]     h1_r;
  logic [63:0]     hprod;
  logic [HB-1:0]   hb1, hb2_r, qb2_r, qr2_r;
  logic [2*HB:0]   pb, pr;
  logic [HB-1:0]   rb, rr;
  logic [16:0]     first_p1;

  assign tcp      = (ip_protocol == psfrl_pkg::PROTO_TCP) && transport_ok;
  assign udp      = (ip_protocol == psfrl_pkg::PROTO_UDP) && transport_ok;
  assign psh_pay  = tcp && flag_psh && (payload_length != 16'd0);
  assign first_p1 = {9'd0, payload_first} + 17'd1;
  assign game     = psh_pay && (dest_port >= psfrl_pkg::GAME_PORT_LOW) &&
                    (dest_port <= psfrl_pkg::GAME_PORT_HIGH) &&
                    (payload_length >= 16'd2) && (first_p1 <= {1'b0, payload_length}) &&
                    (payload_second == 8'd0);

  always_comb begin
    cls_in        = '0;
    cls_in.ok     = frame_ok;
    cls_in.syn_op = tcp && flag_syn && !flag_ack;
    cls_in.hs_op  = game;
    cls_in.ssh_op = psh_pay && (dest_port == psfrl_pkg::SSH_PORT);
    cls_in.udp_op = udp;
    cls_in.dns    = (dest_port == psfrl_pkg::DNS_PORT);
    cls_in.src    = source_addr;
    cls_in.dport  = dest_port;
    cls_in.now    = time_ns;
  end

  assign adv     = !(v2_r && q_full);
  assign in_full = busy || !adv;
  assign acc     = in_push && !in_full;

  assign hprod = {32'd0, c0_r.src} * {32'd0, psfrl_pkg::HASH_MULT};
  assign hb1   = h1_r[31:32-HB];
  assign pb    = hb1 * MB[HB:0];
  assign pr    = hb1 * MR[HB:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= acc;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_r  <= cls_in;
      c1_r  <= c0_r;
      h1_r  <= hprod[31:0];
      c2_r  <= c1_r;
      hb2_r <= hb1;
      qb2_r <= HB'(pb >> (HB + SB));
      qr2_r <= HB'(pr >> (HB + SR));
    end
  end

  assign rb          = hb2_r - HB'(qb2_r * DB);
  assign rr          = hb2_r - HB'(qr2_r * DR);
  assign q_push      = v2_r && !q_full;
  assign q_cls       = c2_r;
  assign q_ban_slot  = rb[SB-1:0];
  assign q_rate_slot = rr[SR-1:0];

endmodule

// ===== design/psfrl_back.sv =====
// Back part: clears the tag tables after reset, then per item reads the tables,
// updates the counters, enters bans and produces the result. Depends on psfrl_pkg, psfrl_ram.
module psfrl_back #(
  parameter int BAN_DEPTH  = 4096,
  parameter int RATE_DEPTH = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  psfrl_pkg::cfg_t               cfg,
  output logic                          busy,
  input  logic                          q_empty,
  input  psfrl_pkg::cls_t               q_cls,
  input  logic [$clog2(BAN_DEPTH)-1:0]  q_ban_slot,
  input  logic [$clog2(RATE_DEPTH)-1:0] q_rate_slot,
  output logic                          q_pop,
  input  logic                          o_full,
  output logic                          o_push,
  output psfrl_pkg::res_t               o_res
);

  localparam int SB  = $clog2(BAN_DEPTH);
  localparam int SR  = $clog2(RATE_DEPTH);
  localparam int CW  = COUNT_BITS;
  localparam int CLR = (BAN_DEPTH > RATE_DEPTH) ? BAN_DEPTH : RATE_DEPTH;
  localparam int KW  = $clog2(CLR) + 1;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EVAL} state_t;

  state_t          state_r;
  logic [KW-1:0]   clr_r;
  psfrl_pkg::cls_t cur_r;
  logic [SB-1:0]   bslot_r;
  logic [SR-1:0]   rslot_r;

  logic [32:0]   ban_rd, syn_tag_rd, hs_tag_rd, udp_tag_rd;
  logic [63:0]   syn_time_rd, hs_time_rd, udp_time_rd;
  logic [CW-1:0] syn_cnt_rd, hs_cnt_rd, udp_cnt_rd;
  logic [CW-1:0] syn_new, hs_new, udp_new;
  logic          clearing, eval, ban_hit, go, syn_hit, hs_hit, udp_hit;
  logic          syn_ban, hs_do, hs_ban, udp_do, udp_ban;
  logic [15:0]   udp_lim;
  psfrl_pkg::reason_t reason;

  logic          ban_we, ban_tag_we, rate_tag_we;
  logic          syn_we, hs_we, udp_we;
  logic [SB-1:0] ban_wa;
  logic [SR-1:0] rate_wa;
  logic [32:0]   ban_wd, syn_tag_wd, hs_tag_wd, udp_tag_wd;

  function automatic logic [CW-1:0] bump(input logic hit, input logic [63:0] now,
                                         input logic [63:0] last, input logic [31:0] win,
                                         input logic [CW-1:0] cnt);
    logic [63:0] d;
    d = now - last;
    if (hit && (d <= {32'd0, win})) begin
      bump = (&cnt) ? cnt : cnt + CW'(1);
    end else begin
      bump = CW'(1);
    end
  endfunction

  assign clearing = (state_r == ST_CLEAR);
  assign eval     = (state_r == ST_EVAL);
  assign busy     = clearing;
  assign q_pop    = (state_r == ST_IDLE) && !q_empty && !o_full;

  assign ban_hit = ban_rd[32] && (ban_rd[31:0] == cur_r.src);
  assign go      = cur_r.ok && !ban_hit;
  assign syn_hit = syn_tag_rd[32] && (syn_tag_rd[31:0] == cur_r.src);
  assign hs_hit  = hs_tag_rd[32] && (hs_tag_rd[31:0] == cur_r.src);
  assign udp_hit = udp_tag_rd[32] && (udp_tag_rd[31:0] == cur_r.src);

  assign syn_new = bump(syn_hit, cur_r.now, syn_time_rd, cfg.syn_window, syn_cnt_rd);
  assign hs_new  = bump(hs_hit, cur_r.now, hs_time_rd, cfg.hs_window, hs_cnt_rd);
  assign udp_new = bump(udp_hit, cur_r.now, udp_time_rd, cfg.udp_window, udp_cnt_rd);
  assign udp_lim = cur_r.dns ? cfg.dns_limit : cfg.udp_limit;

  assign syn_ban = go && cur_r.syn_op && syn_hit && (32'(syn_new) > 32'(cfg.syn_limit));
  assign hs_do   = go && (cur_r.hs_op || cur_r.ssh_op) && !syn_ban;
  assign hs_ban  = hs_do && hs_hit && (32'(hs_new) > 32'(cfg.hs_limit));
  assign udp_do  = go && cur_r.udp_op;
  assign udp_ban = udp_do && udp_hit && (32'(udp_new) > 32'(udp_lim));

  always_comb begin
    if (syn_ban) begin
      reason = psfrl_pkg::RSN_SYN;
    end else if (hs_ban) begin
      reason = cur_r.ssh_op ? psfrl_pkg::RSN_SSH : psfrl_pkg::RSN_HS;
    end else if (udp_ban) begin
      reason = psfrl_pkg::RSN_UDP;
    end else begin
      reason = psfrl_pkg::RSN_NONE;
    end
  end

  always_comb begin
    o_res             = '0;
    o_res.drop        = cur_r.ok && (ban_hit || (reason != psfrl_pkg::RSN_NONE));
    o_res.reason      = reason;
    o_res.banned_addr = (reason != psfrl_pkg::RSN_NONE) ? cur_r.src : 32'd0;
    o_res.rep_valid   = go && cur_r.syn_op;
    o_res.rep_port    = (go && cur_r.syn_op) ? cur_r.dport : 16'd0;
  end
  assign o_push = eval;

  assign syn_we      = eval && go && cur_r.syn_op;
  assign hs_we       = eval && hs_do;
  assign udp_we      = eval && udp_do;
  assign ban_we      = eval && (reason != psfrl_pkg::RSN_NONE);
  assign ban_tag_we  = clearing ? (clr_r < KW'(BAN_DEPTH)) : ban_we;
  assign rate_tag_we = clearing && (clr_r < KW'(RATE_DEPTH));
  assign ban_wa      = clearing ? clr_r[SB-1:0] : bslot_r;
  assign rate_wa     = clearing ? clr_r[SR-1:0] : rslot_r;
  assign ban_wd      = clearing ? 33'd0 : {1'b1, cur_r.src};
  assign syn_tag_wd  = clearing ? 33'd0 : {1'b1, cur_r.src};
  assign hs_tag_wd   = syn_tag_wd;
  assign udp_tag_wd  = syn_tag_wd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + KW'(1);
          if (clr_r == KW'(CLR - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r   <= q_cls;
      bslot_r <= q_ban_slot;
      rslot_r <= q_rate_slot;
    end
  end

  psfrl_ram #(.WIDTH(33), .DEPTH(BAN_DEPTH)) u_ban_tag (
    .clk(clk), .we(ban_tag_we), .waddr(ban_wa), .wdata(ban_wd),
    .re(q_pop), .raddr(q_ban_slot), .rdata(ban_rd));

  psfrl_ram #(.WIDTH(33), .DEPTH(RATE_DEPTH)) u_syn_tag (
    .clk(clk), .we(rate_tag_we || syn_we), .waddr(rate_wa), .wdata(syn_tag_wd),
    .re(q_pop), .raddr(q_rate_slot), .rdata(syn_tag_rd));
  psfrl_ram #(.WIDTH(64), .DEPTH(RATE_DEPTH)) u_syn_time (
    .clk(clk), .we(syn_we), .waddr(rslot_r), .wdata(cur_r.now),
    .re(q_pop), .raddr(q_rate_slot), .rdata(syn_time_rd));
  psfrl_ram #(.WIDTH(CW), .DEPTH(RATE_DEPTH)) u_syn_cnt (
    .clk(clk), .we(syn_we), .waddr(rslot_r), .wdata(syn_new),
    .re(q_pop), .raddr(q_rate_slot), .rdata(syn_cnt_rd));

  psfrl_ram #(.WIDTH(33), .DEPTH(RATE_DEPTH)) u_hs_tag (
    .clk(clk), .we(rate_tag_we || hs_we), .waddr(rate_wa), .wdata(hs_tag_wd),
    .re(q_pop), .raddr(q_rate_slot), .rdata(hs_tag_rd));
  psfrl_ram #(.WIDTH(64), .DEPTH(RATE_DEPTH)) u_hs_time (
    .clk(clk), .we(hs_we), .waddr(rslot_r), .wdata(cur_r.now),
    .re(q_pop), .raddr(q_rate_slot), .rdata(hs_time_rd));
  psfrl_ram #(.WIDTH(CW), .DEPTH(RATE_DEPTH)) u_hs_cnt (
    .clk(clk), .we(hs_we), .waddr(rslot_r), .wdata(hs_new),
    .re(q_pop), .raddr(q_rate_slot), .rdata(hs_cnt_rd));

  psfrl_ram #(.WIDTH(33), .DEPTH(RATE_DEPTH)) u_udp_tag (
    .clk(clk), .we(rate_tag_we || udp_we), .waddr(rate_wa), .wdata(udp_tag_wd),
    .re(q_pop), .raddr(q_rate_slot), .rdata(udp_tag_rd));
  psfrl_ram #(.WIDTH(64), .DEPTH(RATE_DEPTH)) u_udp_time (
    .clk(clk), .we(udp_we), .waddr(rslot_r), .wdata(cur_r.now),
    .re(q_pop), .raddr(q_rate_slot), .rdata(udp_time_rd));
  psfrl_ram #(.WIDTH(CW), .DEPTH(RATE_DEPTH)) u_udp_cnt (
    .clk(clk), .we(udp_we), .waddr(rslot_r), .wdata(udp_new),
    .re(q_pop), .raddr(q_rate_slot), .rdata(udp_cnt_rd));

endmodule
